// File: hw/rtl/btcw_pkg.sv
// Shared types, codes and constants for the bitmap text console writer.
// Used by every RTL module of the block; no dependencies.
`timescale 1ns / 1ps

package btcw_pkg;

    // Fixed glyph geometry and font store size
    localparam int CHAR_WIDTH  = 8;
    localparam int GLYPH_COUNT = 128;
    localparam int GLYPH_ROWS  = 8;
    localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
    localparam int FONT_AW     = $clog2(FONT_DEPTH);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Input operation codes
    localparam logic [1:0] OP_PUT_CHAR   = 2'd0;
    localparam logic [1:0] OP_LOAD_FONT  = 2'd1;
    localparam logic [1:0] OP_SET_CURSOR = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_FRAME_BASE    = 3'd0;
    localparam logic [2:0] REG_ROW_STRIDE    = 3'd1;
    localparam logic [2:0] REG_WIN_LEFT      = 3'd2;
    localparam logic [2:0] REG_WIN_TOP       = 3'd3;
    localparam logic [2:0] REG_WIN_RIGHT     = 3'd4;
    localparam logic [2:0] REG_WIN_BOTTOM    = 3'd5;
    localparam logic [2:0] REG_NL_CLEAR      = 3'd6;
    localparam logic [2:0] REG_WRAP_ENABLE   = 3'd7;

    localparam logic [6:0]  CHAR_NEWLINE  = 7'h0A;
    localparam logic [11:0] CURSOR_MAX    = 12'hFFF;
    localparam logic [3:0]  NL_CLEAR_MAX  = 4'd8;

    // Configuration register set
    typedef struct packed {
        logic [31:0] frame_base;
        logic [9:0]  row_stride;
        logic [11:0] win_left;
        logic [11:0] win_top;
        logic [11:0] win_right;
        logic [11:0] win_bottom;
        logic [3:0]  newline_clear_bytes;
        logic        wrap_enable;
    } cfg_t;

    // Accepted input item as held in the front
    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] char_code;
        logic [2:0] glyph_row;
        logic [7:0] font_byte;
        logic [8:0] cursor_column;
        logic [8:0] cursor_row;
    } in_item_t;

    typedef enum logic [1:0] {
        CMD_LOAD_FONT = 2'd0,
        CMD_GLYPH     = 2'd1,
        CMD_CLEAR     = 2'd2
    } cmd_kind_t;

    // Classified work for the back, before the row offset is formed
    typedef struct packed {
        cmd_kind_t   kind;
        logic [6:0]  char_code;
        logic [2:0]  glyph_row;
        logic [7:0]  font_byte;
        logic [8:0]  x_byte;
        logic [11:0] draw_y;
        logic [3:0]  clear_len;
    } draw_t;

    // Queue entry
    typedef struct packed {
        cmd_kind_t   kind;
        logic [6:0]  char_code;
        logic [2:0]  glyph_row;
        logic [7:0]  font_byte;
        logic [8:0]  x_byte;
        logic [21:0] row_offset;
        logic [3:0]  clear_len;
    } cmd_t;

    // Clamp a cursor sum to the 12-bit range
    function automatic logic [11:0] sat12(input logic [12:0] v);
        return v[12] ? CURSOR_MAX : v[11:0];
    endfunction

endpackage

// File: hw/rtl/btcw_if.sv
// Valid/ready channel interfaces for the input items and the frame buffer writes.
// Depends on nothing beyond plain logic types.
`timescale 1ns / 1ps

interface btcw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [2:0] glyph_row;
    logic [7:0] font_byte;
    logic [8:0] cursor_column;
    logic [8:0] cursor_row;

    modport source (
        output valid, operation, char_code, glyph_row, font_byte, cursor_column, cursor_row,
        input  ready
    );
    modport sink (
        input  valid, operation, char_code, glyph_row, font_byte, cursor_column, cursor_row,
        output ready
    );
endinterface

interface btcw_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] write_address;
    logic [7:0]  write_data;
    logic        last;

    modport source (
        output valid, write_address, write_data, last,
        input  ready
    );
    modport sink (
        input  valid, write_address, write_data, last,
        output ready
    );
endinterface

// File: hw/rtl/bitmap_text_console_writer_top.sv
// Path: an accepted item is held in the holding register, classified into stage two and
// pushed into the queue when it is not full; the back pops it in the idle state and its
// writes pass the read-issue stage and the output register. Throughput: one write per cycle
// while the output accepts, set by the single write walker, its one font memory read port
// and the idle state that pops each next command; a glyph gives LINE_HEIGHT writes.
// Reset (rst_n, async, active low) clears cursor, queue and pipeline and loads register
// defaults; the font memory is not cleared and holds no data until loaded.
`timescale 1ns / 1ps

module bitmap_text_console_writer_top #(
    parameter int LINE_HEIGHT = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    btcw_in_if.sink     in_ch,
    btcw_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    btcw_pkg::cfg_t cfg_reg;
    btcw_pkg::cmd_t q_push_data, q_pop_data;
    logic           q_push, q_pop, q_full, q_empty;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_base          <= 32'd0;
            cfg_reg.row_stride          <= 10'd64;
            cfg_reg.win_left            <= 12'd0;
            cfg_reg.win_top             <= 12'd0;
            cfg_reg.win_right           <= 12'd512;
            cfg_reg.win_bottom          <= 12'd342;
            cfg_reg.newline_clear_bytes <= 4'd4;
            cfg_reg.wrap_enable         <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                btcw_pkg::REG_FRAME_BASE:  cfg_reg.frame_base          <= cfg_data;
                btcw_pkg::REG_ROW_STRIDE:  cfg_reg.row_stride          <= cfg_data[9:0];
                btcw_pkg::REG_WIN_LEFT:    cfg_reg.win_left            <= cfg_data[11:0];
                btcw_pkg::REG_WIN_TOP:     cfg_reg.win_top             <= cfg_data[11:0];
                btcw_pkg::REG_WIN_RIGHT:   cfg_reg.win_right           <= cfg_data[11:0];
                btcw_pkg::REG_WIN_BOTTOM:  cfg_reg.win_bottom          <= cfg_data[11:0];
                btcw_pkg::REG_NL_CLEAR:    cfg_reg.newline_clear_bytes <= cfg_data[3:0];
                btcw_pkg::REG_WRAP_ENABLE: cfg_reg.wrap_enable         <= cfg_data[0];
                default:                   cfg_reg.wrap_enable         <= cfg_reg.wrap_enable;
            endcase
        end
    end

    btcw_front #(
        .LINE_HEIGHT (LINE_HEIGHT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_push_data)
    );

    btcw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    btcw_back #(
        .LINE_HEIGHT (LINE_HEIGHT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (q_pop_data),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

// File: hw/rtl/btcw_queue.sv
// Command queue between the front and the back of the console writer.
// Depends on btcw_pkg for cmd_t and the queue depth.
`timescale 1ns / 1ps

module btcw_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  btcw_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output btcw_pkg::cmd_t pop_data,
    output logic           empty
);

    btcw_pkg::cmd_t                   entry_reg [btcw_pkg::QUEUE_DEPTH];
    logic [btcw_pkg::QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [btcw_pkg::QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [btcw_pkg::QUEUE_CW-1:0]    count_reg, count_next;
    logic                             do_push, do_pop;

    assign full     = (count_reg == btcw_pkg::QUEUE_CW'(btcw_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == btcw_pkg::QUEUE_AW'(btcw_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == btcw_pkg::QUEUE_AW'(btcw_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/btcw_front.sv
// Front of the console writer: accepts items, keeps the cursor and classifies the work.
// Depends on btcw_pkg and btcw_in_if; feeds btcw_queue.
`timescale 1ns / 1ps

module btcw_front #(
    parameter int LINE_HEIGHT = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  btcw_pkg::cfg_t    cfg,
    btcw_in_if.sink           in_ch,
    input  logic              q_full,
    output logic              q_push,
    output btcw_pkg::cmd_t    q_data
);

    btcw_pkg::in_item_t in_item_reg;
    logic               in_valid_reg, in_valid_next;
    btcw_pkg::draw_t    s2_reg, s2_next;
    logic               s2_valid_reg, s2_valid_next;
    logic [11:0]        cursor_x_reg, cursor_x_next;
    logic [11:0]        cursor_y_reg, cursor_y_next;

    logic               s1_go;
    logic               need_entry;
    btcw_pkg::draw_t    s1_draw;
    logic [6:0]         ch;

    // Character placement terms
    logic [12:0]        x_end;
    logic               at_right;
    logic [11:0]        y_down;
    logic [11:0]        x_wrap, y_wrap, y_draw;
    logic               at_bottom;
    logic [11:0]        x_after;

    // Newline clear length terms
    logic               nl_has_room;
    logic [11:0]        nl_room;
    logic [3:0]         nl_cap, nl_len;

    // Set cursor terms
    logic [12:0]        row_span;

    assign ch = in_item_reg.char_code[6:0];

    assign x_end     = {1'b0, cursor_x_reg} + 13'(btcw_pkg::CHAR_WIDTH);
    assign at_right  = (x_end >= {1'b0, cfg.win_right});
    assign y_down    = btcw_pkg::sat12({1'b0, cursor_y_reg} + 13'(LINE_HEIGHT));
    assign x_wrap    = at_right ? cfg.win_left : cursor_x_reg;
    assign y_wrap    = at_right ? y_down : cursor_y_reg;
    assign at_bottom = (({1'b0, y_wrap} + 13'(LINE_HEIGHT - 1)) >= {1'b0, cfg.win_bottom});
    assign y_draw    = at_bottom ? cfg.win_top : y_wrap;
    assign x_after   = btcw_pkg::sat12({1'b0, x_wrap} + 13'(btcw_pkg::CHAR_WIDTH));

    assign nl_has_room = (cfg.win_right > cursor_x_reg);
    assign nl_room     = cfg.win_right - cursor_x_reg;
    assign nl_cap      = (cfg.newline_clear_bytes > btcw_pkg::NL_CLEAR_MAX)
                       ? btcw_pkg::NL_CLEAR_MAX : cfg.newline_clear_bytes;
    assign nl_len      = !nl_has_room ? 4'd0
                       : (nl_room < {8'd0, nl_cap}) ? nl_room[3:0] : nl_cap;

    assign row_span = 13'(in_item_reg.cursor_row) * 13'(LINE_HEIGHT);

    // Handshake: hold one item, move it on when stage two can take it
    assign q_push      = s2_valid_reg && !q_full;
    assign s1_go       = in_valid_reg && (!s2_valid_reg || q_push);
    assign in_ch.ready = !in_valid_reg || s1_go;

    // Classify the held item and update the cursor
    always_comb
    begin
        cursor_x_next     = cursor_x_reg;
        cursor_y_next     = cursor_y_reg;
        need_entry        = 1'b0;
        s1_draw.kind      = btcw_pkg::CMD_GLYPH;
        s1_draw.char_code = ch;
        s1_draw.glyph_row = in_item_reg.glyph_row;
        s1_draw.font_byte = in_item_reg.font_byte;
        s1_draw.x_byte    = cursor_x_reg[11:3];
        s1_draw.draw_y    = cursor_y_reg;
        s1_draw.clear_len = nl_len;
        case (in_item_reg.operation)
            btcw_pkg::OP_LOAD_FONT:
            begin
                need_entry   = 1'b1;
                s1_draw.kind = btcw_pkg::CMD_LOAD_FONT;
            end
            btcw_pkg::OP_SET_CURSOR:
            begin
                cursor_x_next = btcw_pkg::sat12(13'(cfg.win_left)
                              + {1'b0, in_item_reg.cursor_column, 3'b000});
                cursor_y_next = btcw_pkg::sat12(13'(cfg.win_top) + row_span);
            end
            btcw_pkg::OP_PUT_CHAR:
            begin
                if (ch == btcw_pkg::CHAR_NEWLINE)
                begin
                    need_entry    = nl_has_room && (nl_len != 4'd0);
                    s1_draw.kind  = btcw_pkg::CMD_CLEAR;
                    cursor_x_next = cfg.win_left;
                    cursor_y_next = y_down;
                end
                else if (!at_right || cfg.wrap_enable)
                begin
                    need_entry     = 1'b1;
                    s1_draw.kind   = btcw_pkg::CMD_GLYPH;
                    s1_draw.x_byte = x_wrap[11:3];
                    s1_draw.draw_y = y_draw;
                    cursor_x_next  = x_after;
                    cursor_y_next  = y_draw;
                end
            end
            default:
            begin
                need_entry = 1'b0;
            end
        endcase
    end

    // Next state of the holding register and stage two
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ch.valid && in_ch.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            in_valid_next = 1'b0;
        end

        s2_next       = s2_reg;
        s2_valid_next = s2_valid_reg;
        if (s1_go)
        begin
            s2_next       = s1_draw;
            s2_valid_next = need_entry;
        end
        else if (q_push)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            s2_valid_reg <= s2_valid_next;
            if (s1_go)
            begin
                cursor_x_reg <= cursor_x_next;
                cursor_y_reg <= cursor_y_next;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_item_reg.operation     <= in_ch.operation;
            in_item_reg.char_code     <= in_ch.char_code;
            in_item_reg.glyph_row     <= in_ch.glyph_row;
            in_item_reg.font_byte     <= in_ch.font_byte;
            in_item_reg.cursor_column <= in_ch.cursor_column;
            in_item_reg.cursor_row    <= in_ch.cursor_row;
        end
        s2_reg <= s2_next;
    end

    // Form the row offset on the way into the queue
    always_comb
    begin
        q_data.kind       = s2_reg.kind;
        q_data.char_code  = s2_reg.char_code;
        q_data.glyph_row  = s2_reg.glyph_row;
        q_data.font_byte  = s2_reg.font_byte;
        q_data.x_byte     = s2_reg.x_byte;
        q_data.row_offset = {10'd0, s2_reg.draw_y} * {12'd0, cfg.row_stride};
        q_data.clear_len  = s2_reg.clear_len;
    end

endmodule

// File: hw/rtl/btcw_back.sv
// Back of the console writer: runs queued commands, owns the font memory, emits writes.
// Depends on btcw_pkg and btcw_out_if; fed by btcw_queue.
`timescale 1ns / 1ps

module btcw_back #(
    parameter int LINE_HEIGHT = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  btcw_pkg::cfg_t    cfg,
    input  logic              q_empty,
    input  btcw_pkg::cmd_t    q_data,
    output logic              q_pop,
    btcw_out_if.source        out_ch
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t       state_reg, state_next;
    logic         is_glyph_reg;
    logic [6:0]   char_reg;
    logic [3:0]   len_reg;
    logic [31:0]  row_addr_reg, row_addr_next;
    logic [2:0]   row_reg, row_next;
    logic [2:0]   byte_reg, byte_next;

    // Read-issue stage and output register
    logic         r_valid_reg, r_valid_next;
    logic [31:0]  r_addr_reg;
    logic         r_last_reg;
    logic         r_glyph_reg;
    logic         out_valid_reg, out_valid_next;
    logic [31:0]  out_addr_reg;
    logic [7:0]   out_data_reg;
    logic         out_last_reg;

    logic [7:0]   font_mem [btcw_pkg::FONT_DEPTH];
    logic [7:0]   font_q;

    logic         start_draw;
    logic         font_we;
    logic         gen_go;
    logic         r_move;
    logic         row_end;
    logic         gen_last;

    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;
    assign font_we    = q_pop && (q_data.kind == btcw_pkg::CMD_LOAD_FONT);
    assign start_draw = q_pop && (q_data.kind != btcw_pkg::CMD_LOAD_FONT);

    assign r_move   = r_valid_reg && (!out_valid_reg || out_ch.ready);
    assign gen_go   = (state_reg == ST_RUN) && (!r_valid_reg || r_move);
    assign row_end  = is_glyph_reg || ({1'b0, byte_reg} == (len_reg - 4'd1));
    assign gen_last = row_end && (row_reg == 3'(LINE_HEIGHT - 1));

    // Walk rows and bytes of the current command
    always_comb
    begin
        state_next    = state_reg;
        row_addr_next = row_addr_reg;
        row_next      = row_reg;
        byte_next     = byte_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_draw)
                begin
                    state_next    = ST_RUN;
                    row_addr_next = cfg.frame_base + 32'(q_data.x_byte)
                                  + 32'(q_data.row_offset);
                    row_next      = '0;
                    byte_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (gen_go)
                begin
                    if (row_end)
                    begin
                        byte_next     = '0;
                        row_next      = row_reg + 3'd1;
                        row_addr_next = row_addr_reg + 32'(cfg.row_stride);
                    end
                    else
                    begin
                        byte_next = byte_reg + 3'd1;
                    end
                    if (gen_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Pipeline valid bits
    always_comb
    begin
        r_valid_next = r_valid_reg;
        if (gen_go)
        begin
            r_valid_next = 1'b1;
        end
        else if (r_move)
        begin
            r_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (r_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            r_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            r_valid_reg   <= r_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command and walk payload
    always_ff @(posedge clk)
    begin
        if (start_draw)
        begin
            is_glyph_reg <= (q_data.kind == btcw_pkg::CMD_GLYPH);
            char_reg     <= q_data.char_code;
            len_reg      <= q_data.clear_len;
        end
        row_addr_reg <= row_addr_next;
        row_reg      <= row_next;
        byte_reg     <= byte_next;
        if (gen_go)
        begin
            r_addr_reg  <= row_addr_reg + 32'(byte_reg);
            r_last_reg  <= gen_last;
            r_glyph_reg <= is_glyph_reg;
        end
        if (r_move)
        begin
            out_addr_reg <= r_addr_reg;
            out_data_reg <= r_glyph_reg ? font_q : 8'd0;
            out_last_reg <= r_last_reg;
        end
    end

    // Font memory: write on load, registered read as each glyph row issues
    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            font_mem[{q_data.char_code, q_data.glyph_row}] <= q_data.font_byte;
        end
        if (gen_go)
        begin
            font_q <= font_mem[{char_reg, row_reg}];
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.write_address = out_addr_reg;
    assign out_ch.write_data    = out_data_reg;
    assign out_ch.last          = out_last_reg;

endmodule
